// ===== sv/mlt_pkg.sv =====
`timescale 1ns / 1ps
package mlt_pkg;

  localparam int NUM_ENTRIES = 256;
  localparam int NUM_BUCKETS = 256;

  localparam int MAC_W  = 48;
  localparam int PORT_W = 4;
  localparam int REQ_W  = 2;
  localparam int HASH_W = 13;
  localparam int ENT_W  = $clog2(NUM_ENTRIES);
  localparam int PTR_W  = $clog2(NUM_ENTRIES + 1);
  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int CLR_N  = (NUM_ENTRIES > NUM_BUCKETS) ? NUM_ENTRIES : NUM_BUCKETS;
  localparam int CLR_W  = $clog2(CLR_N);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_ENTRIES);

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LEARN  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD   = 2'd3;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic              used;
    logic [PTR_W-1:0]  chain;
    logic [PTR_W-1:0]  prev;
    logic [PTR_W-1:0]  next;
  } entry_t;

  typedef struct packed {
    logic mac;
    logic port;
    logic used;
    logic chain;
    logic prev;
    logic next;
  } ent_mask_t;

  typedef struct packed {
    ent_mask_t        mask;
    logic [ENT_W-1:0] addr;
    entry_t           data;
  } ent_wr_t;

  typedef struct packed {
    logic             en;
    logic [BKT_W-1:0] addr;
    logic [PTR_W-1:0] data;
  } bkt_wr_t;

  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] hit_port;
    logic              is_broadcast;
    logic              evicted;
    logic [MAC_W-1:0]  evicted_addr;
  } res_t;

  // xor of the six bytes, byte k shifted left by k, masked to the bucket count
  function automatic logic [BKT_W-1:0] bkt_of(input logic [MAC_W-1:0] a);
    logic [HASH_W-1:0] v;
    v = '0;
    for (int k = 0; k < 6; k++) begin
      v = v ^ (HASH_W'(a[8*(5-k) +: 8]) << k);
    end
    return v[BKT_W-1:0];
  endfunction

  function automatic logic is_bcast(input logic [MAC_W-1:0] a);
    return (a == '0) || (a == '1);
  endfunction

endpackage

// ===== sv/mlt_entry_ram.sv =====
`timescale 1ns / 1ps
module mlt_entry_ram import mlt_pkg::*; (
  input  logic             clk_i,
  input  ent_wr_t          wr_i,
  input  logic [ENT_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  logic [MAC_W-1:0]  mac_mem   [NUM_ENTRIES];
  logic [PORT_W-1:0] port_mem  [NUM_ENTRIES];
  logic              used_mem  [NUM_ENTRIES];
  logic [PTR_W-1:0]  chain_mem [NUM_ENTRIES];
  logic [PTR_W-1:0]  prev_mem  [NUM_ENTRIES];
  logic [PTR_W-1:0]  next_mem  [NUM_ENTRIES];
  entry_t            rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.mask.mac)   mac_mem[wr_i.addr]   <= wr_i.data.mac;
    if (wr_i.mask.port)  port_mem[wr_i.addr]  <= wr_i.data.port;
    if (wr_i.mask.used)  used_mem[wr_i.addr]  <= wr_i.data.used;
    if (wr_i.mask.chain) chain_mem[wr_i.addr] <= wr_i.data.chain;
    if (wr_i.mask.prev)  prev_mem[wr_i.addr]  <= wr_i.data.prev;
    if (wr_i.mask.next)  next_mem[wr_i.addr]  <= wr_i.data.next;
  end

  always_ff @(posedge clk_i) begin
    rdata_q.mac   <= mac_mem[raddr_i];
    rdata_q.port  <= port_mem[raddr_i];
    rdata_q.used  <= used_mem[raddr_i];
    rdata_q.chain <= chain_mem[raddr_i];
    rdata_q.prev  <= prev_mem[raddr_i];
    rdata_q.next  <= next_mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mlt_bucket_ram.sv =====
`timescale 1ns / 1ps
module mlt_bucket_ram import mlt_pkg::*; (
  input  logic             clk_i,
  input  bkt_wr_t          wr_i,
  input  logic [BKT_W-1:0] raddr_i,
  output logic [PTR_W-1:0] rdata_o
);

  logic [PTR_W-1:0] head_mem [NUM_BUCKETS];
  logic [PTR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) head_mem[wr_i.addr] <= wr_i.data;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= head_mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mlt_ctrl.sv =====
`timescale 1ns / 1ps
module mlt_ctrl import mlt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [REQ_W-1:0]  in_req_i,
  input  logic [MAC_W-1:0]  in_mac_i,
  input  logic [PORT_W-1:0] in_port_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_FHEAD  = 5'd2;
  localparam logic [4:0] S_FWALK  = 5'd3;
  localparam logic [4:0] S_DECIDE = 5'd4;
  localparam logic [4:0] S_DEL2   = 5'd5;
  localparam logic [4:0] S_TREAD  = 5'd6;
  localparam logic [4:0] S_EHEAD  = 5'd7;
  localparam logic [4:0] S_EWALK  = 5'd8;
  localparam logic [4:0] S_EUNL   = 5'd9;
  localparam logic [4:0] S_NRD    = 5'd10;
  localparam logic [4:0] S_NHEAD  = 5'd11;
  localparam logic [4:0] S_L1     = 5'd12;
  localparam logic [4:0] S_L2     = 5'd13;
  localparam logic [4:0] S_L3     = 5'd14;
  localparam logic [4:0] S_L4     = 5'd15;
  localparam logic [4:0] S_OUT    = 5'd16;

  logic [4:0]        state_q, state_d;
  logic [CLR_W-1:0]  clr_q, clr_d;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [MAC_W-1:0]  mac_q, mac_d;
  logic [PORT_W-1:0] port_q, port_d;
  logic [PTR_W-1:0]  cur_q, cur_d;
  logic [PTR_W-1:0]  prv_q, prv_d;
  logic [PTR_W-1:0]  e_q, e_d;
  logic [PTR_W-1:0]  lp_q, lp_d;
  logic [PTR_W-1:0]  ln_q, ln_d;
  logic [PTR_W-1:0]  tchain_q, tchain_d;
  logic [BKT_W-1:0]  bkt_q, bkt_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic              tohead_q, tohead_d;
  logic              hit_q, hit_d;
  logic [PORT_W-1:0] hport_q, hport_d;
  logic              ev_q, ev_d;
  logic [MAC_W-1:0]  evaddr_q, evaddr_d;

  ent_wr_t           ent_wr;
  bkt_wr_t           bkt_wr;
  logic [ENT_W-1:0]  ent_raddr;
  logic [BKT_W-1:0]  bkt_raddr;
  entry_t            ent_rd;
  logic [PTR_W-1:0]  bkt_rd;
  logic [ENT_W-1:0]  clr_idx;

  mlt_entry_ram u_entry_ram (
    .clk_i   (clk_i),
    .wr_i    (ent_wr),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rd)
  );

  mlt_bucket_ram u_bucket_ram (
    .clk_i   (clk_i),
    .wr_i    (bkt_wr),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rd)
  );

  assign clr_idx = clr_q[ENT_W-1:0];

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    req_d     = req_q;
    mac_d     = mac_q;
    port_d    = port_q;
    cur_d     = cur_q;
    prv_d     = prv_q;
    e_d       = e_q;
    lp_d      = lp_q;
    ln_d      = ln_q;
    tchain_d  = tchain_q;
    bkt_d     = bkt_q;
    head_d    = head_q;
    tail_d    = tail_q;
    tohead_d  = tohead_q;
    hit_d     = hit_q;
    hport_d   = hport_q;
    ev_d      = ev_q;
    evaddr_d  = evaddr_q;
    ent_wr    = '0;
    bkt_wr    = '0;
    ent_raddr = cur_q[ENT_W-1:0];
    bkt_raddr = bkt_of(mac_q);
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_CLR: begin
        if ({1'b0, clr_q} < (CLR_W + 1)'(NUM_ENTRIES)) begin
          ent_wr.mask.port  = 1'b1;
          ent_wr.mask.used  = 1'b1;
          ent_wr.mask.chain = 1'b1;
          ent_wr.mask.prev  = 1'b1;
          ent_wr.mask.next  = 1'b1;
          ent_wr.addr       = clr_idx;
          ent_wr.data.chain = NIL;
          ent_wr.data.prev  = (clr_idx == '0) ? NIL : PTR_W'(clr_idx) - PTR_W'(1);
          ent_wr.data.next  = PTR_W'(clr_idx) + PTR_W'(1);
        end
        if ({1'b0, clr_q} < (CLR_W + 1)'(NUM_BUCKETS)) begin
          bkt_wr.en   = 1'b1;
          bkt_wr.addr = clr_q[BKT_W-1:0];
          bkt_wr.data = NIL;
        end
        if (clr_q == CLR_W'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + CLR_W'(1);
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        bkt_raddr  = bkt_of(in_mac_i);
        if (in_valid_i) begin
          req_d    = in_req_i;
          mac_d    = in_mac_i;
          port_d   = in_port_i;
          hit_d    = 1'b0;
          hport_d  = '0;
          ev_d     = 1'b0;
          evaddr_d = '0;
          state_d  = S_FHEAD;
        end
      end
      S_FHEAD: begin
        if (bkt_rd == NIL) begin
          state_d = S_DECIDE;
        end else begin
          cur_d     = bkt_rd;
          prv_d     = NIL;
          ent_raddr = bkt_rd[ENT_W-1:0];
          state_d   = S_FWALK;
        end
      end
      S_FWALK: begin
        if (ent_rd.used && (ent_rd.mac == mac_q)) begin
          hit_d    = 1'b1;
          hport_d  = ent_rd.port;
          e_d      = cur_q;
          lp_d     = ent_rd.prev;
          ln_d     = ent_rd.next;
          tchain_d = ent_rd.chain;
          state_d  = S_DECIDE;
        end else begin
          prv_d     = cur_q;
          cur_d     = ent_rd.chain;
          ent_raddr = ent_rd.chain[ENT_W-1:0];
          if (ent_rd.chain == NIL) state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (req_q)
          REQ_LOOKUP: begin
            tohead_d = 1'b1;
            state_d  = hit_q ? S_L1 : S_OUT;
          end
          REQ_LEARN: begin
            tohead_d = 1'b1;
            if (hit_q) begin
              ent_wr.mask.port = 1'b1;
              ent_wr.addr      = e_q[ENT_W-1:0];
              ent_wr.data.port = port_q;
              state_d          = S_L1;
            end else begin
              e_d       = tail_q;
              ent_raddr = tail_q[ENT_W-1:0];
              state_d   = S_TREAD;
            end
          end
          REQ_DELETE: begin
            if (hit_q) begin
              // drop from the hash chain
              if (prv_q == NIL) begin
                bkt_wr.en   = 1'b1;
                bkt_wr.addr = bkt_of(mac_q);
                bkt_wr.data = tchain_q;
              end else begin
                ent_wr.mask.chain = 1'b1;
                ent_wr.addr       = prv_q[ENT_W-1:0];
                ent_wr.data.chain = tchain_q;
              end
              state_d = S_DEL2;
            end else begin
              state_d = S_OUT;
            end
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_DEL2: begin
        ent_wr.mask.chain = 1'b1;
        ent_wr.mask.used  = 1'b1;
        ent_wr.addr       = e_q[ENT_W-1:0];
        ent_wr.data.chain = NIL;
        ent_wr.data.used  = 1'b0;
        tohead_d          = 1'b0;
        state_d           = S_L1;
      end
      S_TREAD: begin
        lp_d     = ent_rd.prev;
        ln_d     = ent_rd.next;
        tchain_d = ent_rd.chain;
        if (ent_rd.used) begin
          ev_d      = 1'b1;
          evaddr_d  = ent_rd.mac;
          bkt_d     = bkt_of(ent_rd.mac);
          bkt_raddr = bkt_of(ent_rd.mac);
          state_d   = S_EHEAD;
        end else begin
          state_d = S_NHEAD;
        end
      end
      S_EHEAD: begin
        cur_d = bkt_rd;
        prv_d = NIL;
        if (bkt_rd == e_q) begin
          state_d = S_EUNL;
        end else begin
          ent_raddr = bkt_rd[ENT_W-1:0];
          state_d   = S_EWALK;
        end
      end
      S_EWALK: begin
        if (ent_rd.chain == e_q) begin
          prv_d   = cur_q;
          state_d = S_EUNL;
        end else if (ent_rd.chain == NIL) begin
          state_d = S_NRD;
        end else begin
          cur_d     = ent_rd.chain;
          ent_raddr = ent_rd.chain[ENT_W-1:0];
        end
      end
      S_EUNL: begin
        if (prv_q == NIL) begin
          bkt_wr.en   = 1'b1;
          bkt_wr.addr = bkt_q;
          bkt_wr.data = tchain_q;
        end else begin
          ent_wr.mask.chain = 1'b1;
          ent_wr.addr       = prv_q[ENT_W-1:0];
          ent_wr.data.chain = tchain_q;
        end
        state_d = S_NRD;
      end
      S_NRD: begin
        state_d = S_NHEAD;
      end
      S_NHEAD: begin
        ent_wr.mask.mac   = 1'b1;
        ent_wr.mask.port  = 1'b1;
        ent_wr.mask.used  = 1'b1;
        ent_wr.mask.chain = 1'b1;
        ent_wr.addr       = e_q[ENT_W-1:0];
        ent_wr.data.mac   = mac_q;
        ent_wr.data.port  = port_q;
        ent_wr.data.used  = 1'b1;
        ent_wr.data.chain = bkt_rd;
        bkt_wr.en         = 1'b1;
        bkt_wr.addr       = bkt_of(mac_q);
        bkt_wr.data       = e_q;
        state_d           = S_L1;
      end
      S_L1: begin
        if (lp_q != NIL) begin
          ent_wr.mask.next = 1'b1;
          ent_wr.addr      = lp_q[ENT_W-1:0];
          ent_wr.data.next = ln_q;
        end else begin
          head_d = ln_q;
        end
        state_d = S_L2;
      end
      S_L2: begin
        if (ln_q != NIL) begin
          ent_wr.mask.prev = 1'b1;
          ent_wr.addr      = ln_q[ENT_W-1:0];
          ent_wr.data.prev = lp_q;
        end else begin
          tail_d = lp_q;
        end
        state_d = S_L3;
      end
      S_L3: begin
        ent_wr.mask.prev = 1'b1;
        ent_wr.mask.next = 1'b1;
        ent_wr.addr      = e_q[ENT_W-1:0];
        if (tohead_q) begin
          ent_wr.data.next = head_q;
          ent_wr.data.prev = NIL;
        end else begin
          ent_wr.data.prev = tail_q;
          ent_wr.data.next = NIL;
        end
        state_d = S_L4;
      end
      S_L4: begin
        if (tohead_q) begin
          if (head_q != NIL) begin
            ent_wr.mask.prev = 1'b1;
            ent_wr.addr      = head_q[ENT_W-1:0];
            ent_wr.data.prev = e_q;
          end else begin
            tail_d = e_q;
          end
          head_d = e_q;
        end else begin
          if (tail_q != NIL) begin
            ent_wr.mask.next = 1'b1;
            ent_wr.addr      = tail_q[ENT_W-1:0];
            ent_wr.data.next = e_q;
          end else begin
            head_d = e_q;
          end
          tail_d = e_q;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      head_q   <= '0;
      tail_q   <= PTR_W'(NUM_ENTRIES - 1);
      tohead_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      tohead_q <= tohead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    mac_q    <= mac_d;
    port_q   <= port_d;
    cur_q    <= cur_d;
    prv_q    <= prv_d;
    e_q      <= e_d;
    lp_q     <= lp_d;
    ln_q     <= ln_d;
    tchain_q <= tchain_d;
    bkt_q    <= bkt_d;
    hit_q    <= hit_d;
    hport_q  <= hport_d;
    ev_q     <= ev_d;
    evaddr_q <= evaddr_d;
  end

  assign res_o.hit          = hit_q;
  assign res_o.hit_port     = hport_q;
  assign res_o.is_broadcast = is_bcast(mac_q);
  assign res_o.evicted      = ev_q;
  assign res_o.evicted_addr = evaddr_q;

endmodule

// ===== sv/mac_learning_table_lru.sv =====
`timescale 1ns / 1ps
// channel  side    tvalid/tready  tdata                          tuser
// request  slave   s_axis_*       mac_addr, port_id (56 bits)    req_type
// result   master  m_axis_*       hit .. evicted_addr (56 bits)  -
//
// one request at a time; each reads its bucket head and walks its hash chain, then
// a lookup hit or a learn of a present address relinks the entry in the lru list,
// a delete hit first unlinks it from its chain and makes it the oldest, a learn of
// a new address reuses the oldest entry, unlinked from its old chain if evicted
// after reset a clearing pass over all 256 entries and buckets initializes both
// memories, no transfer is taken meanwhile
// a finished result sits in the output register; the next request is taken
// while it waits, the engine holds only when a second result is ready
module mac_learning_table_lru import mlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // mac_addr[47:0], port_id[51:48]
  input  logic [1:0]  s_axis_tuser_i,  // req_type[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o  // hit[0], hit_port[4:1], is_broadcast[5],
                                      // evicted[6], evicted_addr[54:7]
);

  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid_q, out_valid_d;
  res_t out_q;

  mlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_req_i    (s_axis_tuser_i),
    .in_mac_i    (s_axis_tdata_i[47:0]),
    .in_port_i   (s_axis_tdata_i[51:48]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.evicted_addr, out_q.evicted, out_q.is_broadcast,
                            out_q.hit_port, out_q.hit};

endmodule

// ===== bench/mac_learning_table_lru_chk.sv =====
`timescale 1ns / 1ps
module mac_learning_table_lru_chk import mlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [55:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [55:0] m_axis_tdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o,
  output int          evict_count_o
);

  localparam int NE = NUM_ENTRIES;
  localparam int NB = NUM_BUCKETS;
  localparam int NPORTS = 16;

  logic [MAC_W-1:0]  tbl_mac [NE];
  logic [PORT_W-1:0] tbl_port [NE];
  logic              tbl_used [NE];
  int                tbl_chain [NE];
  int                tbl_prev [NE];
  int                tbl_next [NE];
  int                bkt_head [NB];
  int                mru, lru;
  res_t              lookup_results [$];

  function automatic int hash_mac(input logic [MAC_W-1:0] a);
    int v;
    v = 0;
    for (int k = 0; k < 6; k++) v = v ^ (int'(a[8*(5-k) +: 8]) << k);
    return v % NB;
  endfunction

  function automatic int find_mac(input logic [MAC_W-1:0] a);
    int e, steps;
    e = bkt_head[hash_mac(a)];
    steps = 0;
    while (e < NE && steps < NE) begin
      if (tbl_used[e] && tbl_mac[e] == a) return e;
      e = tbl_chain[e];
      steps++;
    end
    return NE;
  endfunction

  function automatic void chain_remove(input int e);
    int b, cur, steps;
    b = hash_mac(tbl_mac[e]);
    cur = bkt_head[b];
    steps = 0;
    if (cur == e) bkt_head[b] = tbl_chain[e];
    else begin
      while (cur < NE && steps < NE) begin
        if (tbl_chain[cur] == e) begin
          tbl_chain[cur] = tbl_chain[e];
          break;
        end
        cur = tbl_chain[cur];
        steps++;
      end
    end
    tbl_chain[e] = NE;
  endfunction

  function automatic void age_detach(input int e);
    int p, n;
    p = tbl_prev[e];
    n = tbl_next[e];
    if (p < NE) tbl_next[p] = n; else mru = n;
    if (n < NE) tbl_prev[n] = p; else lru = p;
    tbl_prev[e] = NE;
    tbl_next[e] = NE;
  endfunction

  function automatic void make_newest(input int e);
    age_detach(e);
    tbl_next[e] = mru;
    tbl_prev[e] = NE;
    if (mru < NE) tbl_prev[mru] = e; else lru = e;
    mru = e;
  endfunction

  function automatic void make_oldest(input int e);
    age_detach(e);
    tbl_prev[e] = lru;
    tbl_next[e] = NE;
    if (lru < NE) tbl_next[lru] = e; else mru = e;
    lru = e;
  endfunction

  function automatic res_t apply_request(input logic [1:0] req, input logic [MAC_W-1:0] a,
                                         input logic [PORT_W-1:0] p);
    res_t r;
    int e, t, b;
    r = '0;
    e = find_mac(a);
    if (e < NE) begin
      r.hit = 1'b1;
      r.hit_port = tbl_port[e];
    end
    r.is_broadcast = (a == '0) || (a == '1);
    if (req == REQ_LOOKUP) begin
      if (e < NE) make_newest(e);
    end else if (req == REQ_LEARN) begin
      if (int'(p) < NPORTS) begin
        if (e < NE) begin
          tbl_port[e] = p;
          make_newest(e);
        end else begin
          t = lru;
          if (t < NE) begin
            if (tbl_used[t]) begin
              r.evicted = 1'b1;
              r.evicted_addr = tbl_mac[t];
              chain_remove(t);
              tbl_used[t] = 1'b0;
            end
            tbl_mac[t] = a;
            tbl_port[t] = p;
            b = hash_mac(a);
            tbl_chain[t] = bkt_head[b];
            bkt_head[b] = t;
            tbl_used[t] = 1'b1;
            make_newest(t);
          end
        end
      end
    end else if (req == REQ_DELETE) begin
      if (e < NE) begin
        chain_remove(e);
        tbl_used[e] = 1'b0;
        make_oldest(e);
      end
    end
    return r;
  endfunction

  assign pending_o = lookup_results.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    res_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < NE; i++) begin
        tbl_mac[i] = '0;
        tbl_port[i] = '0;
        tbl_used[i] = 1'b0;
        tbl_chain[i] = NE;
        tbl_prev[i] = (i == 0) ? NE : i - 1;
        tbl_next[i] = i + 1;
      end
      for (int i = 0; i < NB; i++) bkt_head[i] = NE;
      mru = 0;
      lru = NE - 1;
      lookup_results.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
      evict_count_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.hit = m_axis_tdata_i[0];
        got.hit_port = m_axis_tdata_i[4:1];
        got.is_broadcast = m_axis_tdata_i[5];
        got.evicted = m_axis_tdata_i[6];
        got.evicted_addr = m_axis_tdata_i[54:7];
        result_count_o <= result_count_o + 1;
        if (got.evicted) evict_count_o <= evict_count_o + 1;
        if (lookup_results.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h", m_axis_tdata_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = lookup_results.pop_front();
          if (got !== want || m_axis_tdata_i[55] !== 1'b0) begin
            if (fail_count_o < 10)
              $display("mismatch exp hit %b port %h bc %b ev %b addr %h / got %b %h %b %b %h",
                       want.hit, want.hit_port, want.is_broadcast, want.evicted,
                       want.evicted_addr, got.hit, got.hit_port, got.is_broadcast,
                       got.evicted, got.evicted_addr);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        lookup_results.push_back(apply_request(s_axis_tuser_i, s_axis_tdata_i[47:0],
                                               s_axis_tdata_i[51:48]));
    end
  end

endmodule

// ===== bench/mac_learning_table_lru_tb.sv =====
`timescale 1ns / 1ps
module mac_learning_table_lru_tb;
  import mlt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  int          fail_count, pending, result_count, evict_count;
  logic [MAC_W-1:0] mac_pool [64];
  bit          sink_run = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  mac_learning_table_lru DUT (.*);

  mac_learning_table_lru_chk u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .s_axis_tuser_i, .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o), .fail_count_o(fail_count),
    .pending_o(pending), .result_count_o(result_count), .evict_count_o(evict_count)
  );

  // receiver stall pattern: cycles through open, mostly open and mostly stalled stretches
  always @(posedge clk_i) begin
    int mode;
    if (!sink_run) m_axis_tready_i <= 1'b0;
    else begin
      mode = ($time / 400) % 3;
      if (mode == 0) m_axis_tready_i <= 1'b1;
      else if (mode == 1) m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      else m_axis_tready_i <= ($urandom_range(0, 4) == 0);
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [MAC_W-1:0] a,
                              input logic [PORT_W-1:0] p);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= req;
    s_axis_tdata_i <= {4'b0, p, a};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic gap_after(input int burst_left);
    int n;
    if (burst_left == 0) begin
      n = $urandom_range(1, 12);
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    int burst, r, k;
    logic [MAC_W-1:0] a;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    sink_run = 1'b1;
    for (int i = 0; i < 64; i++)
      mac_pool[i] = 48'({$urandom(), $urandom()});
    // two pool entries share a bucket to force chain walks
    mac_pool[1] = 48'h0000_0000_0200;
    mac_pool[2] = 48'h0000_0000_0001;
    // directed: extremes, every request kind, special cases
    send_request(REQ_LOOKUP, 48'h0, 4'h0);
    send_request(REQ_LEARN, 48'h0, 4'hF);
    send_request(REQ_LEARN, 48'hFFFF_FFFF_FFFF, 4'h0);
    send_request(REQ_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'h0);
    send_request(REQ_LEARN, mac_pool[1], 4'h5);
    send_request(REQ_LEARN, mac_pool[2], 4'hA);
    send_request(REQ_LOOKUP, mac_pool[2], 4'h0);
    send_request(REQ_LEARN, mac_pool[1], 4'h3);
    send_request(REQ_DELETE, mac_pool[1], 4'h0);
    send_request(REQ_DELETE, mac_pool[1], 4'h0);
    send_request(REQ_RSVD, mac_pool[2], 4'h7);
    send_request(REQ_LOOKUP, mac_pool[1], 4'h0);
    send_request(REQ_DELETE, 48'h0, 4'hF);
    send_request(REQ_LOOKUP, 48'hAAAA_5555_AAAA, 4'hF);
    send_request(REQ_LOOKUP, 48'h5555_AAAA_5555, 4'h0);
    // fill past capacity so learns evict
    for (int i = 0; i < 300; i++)
      send_request(REQ_LEARN, 48'({$urandom(), $urandom()}),
                   4'($urandom_range(0, 15)));
    s_axis_tvalid_i <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk_i);
    // random traffic, mostly on a small pool for hits, in bursts
    burst = 0;
    for (int i = 0; i < 700; i++) begin
      if (burst == 0) burst = $urandom_range(1, 20);
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 63);
      a = (r < 80) ? mac_pool[k] : 48'({$urandom(), $urandom()});
      if ($urandom_range(0, 49) == 0) a = $urandom_range(0, 1) ? 48'h0 : '1;
      r = $urandom_range(0, 99);
      send_request((r < 40) ? REQ_LOOKUP : (r < 75) ? REQ_LEARN :
                   (r < 97) ? REQ_DELETE : REQ_RSVD,
                   a, 4'($urandom_range(0, 15)));
      burst--;
      gap_after(burst);
    end
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d results checked, %0d with eviction", result_count, evict_count);
    if (fail_count == 0) $display("mac_learning_table_lru_tb passed");
    else $display("mac_learning_table_lru_tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("mac_learning_table_lru_tb failed");
    $finish;
  end

endmodule
